@@ rtl/core/u8tt_pkg.sv @@
`default_nettype none

package u8tt_pkg;

    // sizing
    localparam int OFFSET_BITS    = 16;
    localparam int RING_DEPTH     = 20;
    localparam int KEEP_BUF_BYTES = 256;
    localparam int QUEUE_DEPTH    = 4;

    localparam int START_BITS    = 16;
    localparam int CMP_BITS      = ((OFFSET_BITS > START_BITS) ? OFFSET_BITS : START_BITS) + 1;
    localparam int RING_IDX_BITS = $clog2(RING_DEPTH);
    localparam int RING_CNT_BITS = $clog2(RING_DEPTH + 1);
    localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int KEEP_BITS     = $clog2(KEEP_BUF_BYTES);
    localparam int CP_BITS       = 21;
    localparam int LIMIT_BITS    = 5;
    localparam int UNIT_BITS     = LIMIT_BITS + 1;
    localparam int CFG_IDX_BITS  = 1;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_BITS-1:0] CFG_CJK_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LATIN_LIMIT = 1'b1;
    localparam logic [LIMIT_BITS-1:0]   CJK_LIMIT_RST   = 5'd5;
    localparam logic [LIMIT_BITS-1:0]   LATIN_LIMIT_RST = 5'd20;

    // code point ranges
    localparam logic [CP_BITS-1:0] CJK_A_LO  = 21'h03400;
    localparam logic [CP_BITS-1:0] CJK_A_HI  = 21'h04dbf;
    localparam logic [CP_BITS-1:0] CJK_U_LO  = 21'h04e00;
    localparam logic [CP_BITS-1:0] CJK_U_HI  = 21'h09fff;
    localparam logic [CP_BITS-1:0] CJK_B_LO  = 21'h20000;
    localparam logic [CP_BITS-1:0] CJK_B_HI  = 21'h2a6df;
    localparam logic [CP_BITS-1:0] BMP_MAX   = 21'h0ffff;
    localparam logic [CP_BITS-1:0] UPPER_LO  = 21'h00041;
    localparam logic [CP_BITS-1:0] UPPER_HI  = 21'h0005a;
    localparam logic [CP_BITS-1:0] LOWER_LO  = 21'h00061;
    localparam logic [CP_BITS-1:0] LOWER_HI  = 21'h0007a;

    localparam logic [START_BITS-1:0] START_MAX = '1;

    typedef enum logic [1:0] {
        LANG_OTHER = 2'd1,
        LANG_CJK   = 2'd2,
        LANG_LATIN = 2'd3
    } t_lang;

    // one record between front and back: a code point or the end of text
    typedef struct packed {
        logic                   is_end;
        logic                   ovf;
        logic [OFFSET_BITS-1:0] pos;
        logic [START_BITS-1:0]  start;
        logic                   two;
        t_lang                  lang;
    } t_rec;

    // one ring entry of the trailing run
    typedef struct packed {
        logic                  two;
        logic [START_BITS-1:0] start;
    } t_entry;

    // sequence length announced by a lead byte
    function automatic logic [2:0] seq_need(input logic [7:0] b);
        logic [2:0] need;
        need = 3'd1;
        if ((b & 8'he0) == 8'hc0) need = 3'd2;
        else if ((b & 8'hf0) == 8'he0) need = 3'd3;
        else if ((b & 8'hf8) == 8'hf0) need = 3'd4;
        return need;
    endfunction

    function automatic t_lang classify(input logic [CP_BITS-1:0] cp);
        t_lang lang;
        lang = LANG_OTHER;
        if ((cp >= CJK_A_LO && cp <= CJK_A_HI) || (cp >= CJK_U_LO && cp <= CJK_U_HI) ||
            (cp >= CJK_B_LO && cp <= CJK_B_HI))
            lang = LANG_CJK;
        else if ((cp >= UPPER_LO && cp <= UPPER_HI) || (cp >= LOWER_LO && cp <= LOWER_HI))
            lang = LANG_LATIN;
        return lang;
    endfunction

    // byte offset clipped to the width of a ring entry
    function automatic logic [START_BITS-1:0] sat_start(input logic [OFFSET_BITS-1:0] pos);
        logic [START_BITS-1:0] s;
        if (CMP_BITS'(pos) > CMP_BITS'(START_MAX)) s = START_MAX;
        else s = START_BITS'(pos);
        return s;
    endfunction

    function automatic t_rec make_point(input logic [OFFSET_BITS-1:0] pos,
                                        input logic [CP_BITS-1:0]     cp);
        t_rec r;
        r.is_end = 1'b0;
        r.ovf    = 1'b0;
        r.pos    = '0;
        r.start  = sat_start(pos);
        r.two    = (cp > BMP_MAX);
        r.lang   = classify(cp);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/u8tt_front.sv @@
`default_nettype none

module u8tt_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_present,
    input  wire logic            i_eot,
    output logic                 o_rec_valid,
    output u8tt_pkg::t_rec       o_rec,
    input  wire logic            i_rec_ready
);

    // held item
    logic                              r_busy, n_busy;
    logic [7:0]                        r_byte, n_byte;
    logic                              r_has_byte, n_has_byte;
    logic                              r_eot, n_eot;

    // decoder state
    logic [7:0]                        r_pb [3];
    logic [7:0]                        n_pb [3];
    logic [1:0]                        r_pcount, n_pcount;
    logic [1:0]                        r_fk, n_fk;
    logic [u8tt_pkg::OFFSET_BITS-1:0]  r_pos, n_pos;
    logic                              r_ovf, n_ovf;

    logic                              item_done;
    logic                              byte_done;
    logic                              flush_step;
    logic                              cont;
    logic [2:0]                        need;
    logic [u8tt_pkg::OFFSET_BITS-1:0]  base;
    logic [u8tt_pkg::CP_BITS-1:0]      cp_full;
    u8tt_pkg::t_rec                    flush_rec;
    u8tt_pkg::t_rec                    end_rec;

    assign cont = (r_byte[7:6] == 2'b10);
    assign need = u8tt_pkg::seq_need(r_pb[0]);
    assign base = (r_pos >= u8tt_pkg::OFFSET_BITS'(r_pcount)) ?
                  r_pos - u8tt_pkg::OFFSET_BITS'(r_pcount) : '0;

    // pending byte flushed as a one-byte point
    assign flush_rec = u8tt_pkg::make_point(base + u8tt_pkg::OFFSET_BITS'(r_fk),
                                            u8tt_pkg::CP_BITS'(r_pb[r_fk]));

    // end of text marker
    always_comb begin
        end_rec        = u8tt_pkg::make_point('0, '0);
        end_rec.is_end = 1'b1;
        end_rec.ovf    = r_ovf;
        end_rec.pos    = r_pos;
    end

    // code point of a completed sequence
    always_comb begin
        case (need)
            3'd2:    cp_full = u8tt_pkg::CP_BITS'({r_pb[0][4:0], r_byte[5:0]});
            3'd3:    cp_full = u8tt_pkg::CP_BITS'({r_pb[0][3:0], r_pb[1][5:0], r_byte[5:0]});
            default: cp_full = {r_pb[0][2:0], r_pb[1][5:0], r_pb[2][5:0], r_byte[5:0]};
        endcase
    end

    // one step of the held item per cycle, at most one record out; a step that emits a record waits for i_rec_ready
    always_comb begin
        n_busy      = r_busy;
        n_byte      = r_byte;
        n_has_byte  = r_has_byte;
        n_eot       = r_eot;
        n_pb        = r_pb;
        n_pcount    = r_pcount;
        n_fk        = r_fk;
        n_pos       = r_pos;
        n_ovf       = r_ovf;
        o_rec_valid = 1'b0;
        o_rec       = flush_rec;
        item_done   = 1'b0;
        byte_done   = 1'b0;
        flush_step  = 1'b0;

        if (r_busy) begin
            if (r_has_byte) begin
                if (r_pcount != 2'd0 && cont) begin
                    if ({1'b0, r_pcount} + 3'd1 == need) begin
                        o_rec_valid = 1'b1;
                        o_rec       = u8tt_pkg::make_point(base, cp_full);
                        if (i_rec_ready) begin
                            n_pcount  = 2'd0;
                            byte_done = 1'b1;
                        end
                    end else begin
                        n_pb[r_pcount] = r_byte;
                        n_pcount       = r_pcount + 2'd1;
                        byte_done      = 1'b1;
                    end
                end else if (r_pcount != 2'd0) begin
                    flush_step = 1'b1;
                end else if (u8tt_pkg::seq_need(r_byte) == 3'd1) begin
                    o_rec_valid = 1'b1;
                    o_rec       = u8tt_pkg::make_point(r_pos, u8tt_pkg::CP_BITS'(r_byte));
                    byte_done   = i_rec_ready;
                end else begin
                    n_pb[0]   = r_byte;
                    n_pcount  = 2'd1;
                    byte_done = 1'b1;
                end
            end else if (!r_eot) begin
                item_done = 1'b1;
            end else if (r_pcount != 2'd0) begin
                flush_step = 1'b1;
            end else begin
                o_rec_valid = 1'b1;
                o_rec       = end_rec;
                if (i_rec_ready) begin
                    n_pos     = '0;
                    n_ovf     = 1'b0;
                    n_fk      = 2'd0;
                    item_done = 1'b1;
                end
            end
        end

        // flush of pending bytes, one a cycle while i_rec_ready is high
        if (flush_step) begin
            o_rec_valid = 1'b1;
            o_rec       = flush_rec;
            if (i_rec_ready) begin
                if (r_fk == r_pcount - 2'd1) begin
                    n_pcount = 2'd0;
                    n_fk     = 2'd0;
                end else begin
                    n_fk = r_fk + 2'd1;
                end
            end
        end

        // byte consumed: saturating position
        if (byte_done) begin
            n_has_byte = 1'b0;
            if (&r_pos) n_ovf = 1'b1;
            else n_pos = r_pos + 1'b1;
            if (!r_eot) item_done = 1'b1;
        end

        if (item_done) n_busy = 1'b0;

        o_ready = !r_busy || item_done;

        // new transaction
        if (i_valid && o_ready) begin
            n_busy     = 1'b1;
            n_byte     = i_byte;
            n_has_byte = i_present;
            n_eot      = i_eot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_has_byte <= 1'b0;
            r_eot      <= 1'b0;
            r_pcount   <= 2'd0;
            r_fk       <= 2'd0;
            r_pos      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_has_byte <= n_has_byte;
            r_eot      <= n_eot;
            r_pcount   <= n_pcount;
            r_fk       <= n_fk;
            r_pos      <= n_pos;
            r_ovf      <= n_ovf;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_pb   <= n_pb;
    end

endmodule

`default_nettype wire

@@ rtl/core/u8tt_queue.sv @@
`default_nettype none

module u8tt_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire u8tt_pkg::t_rec  i_rec,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output u8tt_pkg::t_rec       o_rec
);

    u8tt_pkg::t_rec                       r_mem [u8tt_pkg::QUEUE_DEPTH];
    logic [u8tt_pkg::QUEUE_IDX_BITS-1:0]  r_wp, r_rp;
    logic [u8tt_pkg::QUEUE_CNT_BITS-1:0]  r_cnt;
    logic                                 push, pop;

    assign o_ready = (r_cnt != u8tt_pkg::QUEUE_CNT_BITS'(u8tt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                if (r_wp == u8tt_pkg::QUEUE_IDX_BITS'(u8tt_pkg::QUEUE_DEPTH - 1)) r_wp <= '0;
                else r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                if (r_rp == u8tt_pkg::QUEUE_IDX_BITS'(u8tt_pkg::QUEUE_DEPTH - 1)) r_rp <= '0;
                else r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_rec;
    end

endmodule

`default_nettype wire

@@ rtl/core/u8tt_back.sv @@
`default_nettype none

module u8tt_back (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [u8tt_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [u8tt_pkg::LIMIT_BITS-1:0]        i_cfg_data,
    input  wire logic                                   i_rec_valid,
    output logic                                        o_rec_ready,
    input  wire u8tt_pkg::t_rec                         i_rec,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [u8tt_pkg::START_BITS-1:0]             o_start,
    output logic [u8tt_pkg::KEEP_BITS-1:0]              o_len,
    output logic                                        o_latin,
    output logic                                        o_ovf
);

    typedef enum logic {
        BK_RUN,
        BK_WALK
    } t_bstate;

    t_bstate                                r_state, n_state;

    // limits
    logic [u8tt_pkg::LIMIT_BITS-1:0]        r_cjk_lim, n_cjk_lim;
    logic [u8tt_pkg::LIMIT_BITS-1:0]        r_lat_lim, n_lat_lim;

    // trailing run
    u8tt_pkg::t_entry                       r_ring [u8tt_pkg::RING_DEPTH];
    logic [u8tt_pkg::RING_IDX_BITS-1:0]     r_head, n_head;
    logic [u8tt_pkg::RING_CNT_BITS-1:0]     r_entries, n_entries;
    u8tt_pkg::t_lang                        r_lang, n_lang;
    logic                                   ring_we;
    logic [u8tt_pkg::RING_CNT_BITS-1:0]     cnt_base;

    // backward walk
    logic [u8tt_pkg::RING_IDX_BITS-1:0]     r_widx, n_widx;
    logic [u8tt_pkg::RING_CNT_BITS-1:0]     r_wcnt, n_wcnt;
    logic [u8tt_pkg::UNIT_BITS-1:0]         r_units, n_units;
    logic [u8tt_pkg::START_BITS-1:0]        r_wstart, n_wstart;
    logic [u8tt_pkg::OFFSET_BITS-1:0]       r_wpos, n_wpos;
    logic                                   r_wovf, n_wovf;
    logic                                   r_wlatin, n_wlatin;
    logic [u8tt_pkg::LIMIT_BITS-1:0]        r_limit, n_limit;
    u8tt_pkg::t_entry                       walk_e;
    logic [u8tt_pkg::CMP_BITS-1:0]          pos_x, start_x, diff;

    // result register
    logic                                   r_valid, n_valid;
    logic [u8tt_pkg::START_BITS-1:0]        r_start, n_start;
    logic [u8tt_pkg::KEEP_BITS-1:0]         r_len, n_len;
    logic                                   r_latin, n_latin;
    logic                                   r_ovf, n_ovf;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_start     = r_start;
    assign o_len       = r_len;
    assign o_latin     = r_latin;
    assign o_ovf       = r_ovf;

    assign walk_e   = r_ring[r_widx];
    assign cnt_base = (i_rec.lang != r_lang) ? '0 : r_entries;
    assign pos_x    = u8tt_pkg::CMP_BITS'(r_wpos);
    assign start_x  = u8tt_pkg::CMP_BITS'(r_wstart);
    assign diff     = (pos_x >= start_x) ? pos_x - start_x : '0;

    always_comb begin
        n_state   = r_state;
        n_cjk_lim = r_cjk_lim;
        n_lat_lim = r_lat_lim;
        n_head    = r_head;
        n_entries = r_entries;
        n_lang    = r_lang;
        n_widx    = r_widx;
        n_wcnt    = r_wcnt;
        n_units   = r_units;
        n_wstart  = r_wstart;
        n_wpos    = r_wpos;
        n_wovf    = r_wovf;
        n_wlatin  = r_wlatin;
        n_limit   = r_limit;
        n_valid   = r_valid;
        n_start   = r_start;
        n_len     = r_len;
        n_latin   = r_latin;
        n_ovf     = r_ovf;
        ring_we     = 1'b0;
        o_rec_ready = 1'b0;

        // register writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                u8tt_pkg::CFG_CJK_LIMIT:   n_cjk_lim = i_cfg_data;
                u8tt_pkg::CFG_LATIN_LIMIT: n_lat_lim = i_cfg_data;
                default: ;
            endcase
        end

        // result taken downstream
        if (r_valid && i_ready) n_valid = 1'b0;

        case (r_state)
            BK_RUN: begin
                o_rec_ready = !i_rec.is_end || !r_valid;
                if (i_rec_valid && !i_rec.is_end) begin
                    // append point to the trailing run
                    ring_we = 1'b1;
                    n_lang  = i_rec.lang;
                    if (r_head == u8tt_pkg::RING_IDX_BITS'(u8tt_pkg::RING_DEPTH - 1))
                        n_head = '0;
                    else
                        n_head = r_head + 1'b1;
                    if (cnt_base < u8tt_pkg::RING_CNT_BITS'(u8tt_pkg::RING_DEPTH))
                        n_entries = cnt_base + 1'b1;
                    else
                        n_entries = cnt_base;
                end else if (i_rec_valid && !r_valid) begin
                    // end of text: start the walk and clear the run
                    n_state  = BK_WALK;
                    n_wcnt   = (r_lang != u8tt_pkg::LANG_OTHER) ? r_entries : '0;
                    n_widx   = (r_head == '0) ?
                               u8tt_pkg::RING_IDX_BITS'(u8tt_pkg::RING_DEPTH - 1) :
                               r_head - 1'b1;
                    n_units  = '0;
                    n_wstart = u8tt_pkg::START_BITS'(i_rec.pos);
                    n_wpos   = i_rec.pos;
                    n_wovf   = i_rec.ovf;
                    n_wlatin = (r_lang == u8tt_pkg::LANG_LATIN);
                    n_limit  = (r_lang == u8tt_pkg::LANG_CJK) ? r_cjk_lim : r_lat_lim;
                    n_head    = '0;
                    n_entries = '0;
                    n_lang    = u8tt_pkg::LANG_OTHER;
                end
            end
            BK_WALK: begin
                if (r_wcnt == '0 || r_units >= u8tt_pkg::UNIT_BITS'(r_limit)) begin
                    // kept length clamped to the buffer
                    n_state = BK_RUN;
                    n_valid = 1'b1;
                    n_start = r_wstart;
                    n_latin = r_wlatin;
                    n_ovf   = r_wovf;
                    if (diff >= u8tt_pkg::CMP_BITS'(u8tt_pkg::KEEP_BUF_BYTES - 1))
                        n_len = u8tt_pkg::KEEP_BITS'(u8tt_pkg::KEEP_BUF_BYTES - 1);
                    else
                        n_len = u8tt_pkg::KEEP_BITS'(diff);
                end else begin
                    // step one point further back
                    n_wstart = walk_e.start;
                    n_units  = r_units + (walk_e.two ? u8tt_pkg::UNIT_BITS'(2) :
                                                       u8tt_pkg::UNIT_BITS'(1));
                    n_wcnt   = r_wcnt - 1'b1;
                    if (r_widx == '0)
                        n_widx = u8tt_pkg::RING_IDX_BITS'(u8tt_pkg::RING_DEPTH - 1);
                    else
                        n_widx = r_widx - 1'b1;
                end
            end
            default: n_state = BK_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_RUN;
            r_cjk_lim <= u8tt_pkg::CJK_LIMIT_RST;
            r_lat_lim <= u8tt_pkg::LATIN_LIMIT_RST;
            r_head    <= '0;
            r_entries <= '0;
            r_lang    <= u8tt_pkg::LANG_OTHER;
            r_wcnt    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cjk_lim <= n_cjk_lim;
            r_lat_lim <= n_lat_lim;
            r_head    <= n_head;
            r_entries <= n_entries;
            r_lang    <= n_lang;
            r_wcnt    <= n_wcnt;
            r_valid   <= n_valid;
            if (ring_we) r_ring[r_head] <= '{two: i_rec.two, start: i_rec.start};
        end
        r_widx   <= n_widx;
        r_units  <= n_units;
        r_wstart <= n_wstart;
        r_wpos   <= n_wpos;
        r_wovf   <= n_wovf;
        r_wlatin <= n_wlatin;
        r_limit  <= n_limit;
        r_start  <= n_start;
        r_len    <= n_len;
        r_latin  <= n_latin;
        r_ovf    <= n_ovf;
    end

endmodule

`default_nettype wire

@@ rtl/core/utf8_context_tail_trimmer.sv @@
`default_nettype none

// channel     direction  handshake                      payload
// s_axis      in         i_s_axis_tvalid/o_s_axis_tready tdata text byte, tuser byte present,
//                                                         tlast end of text
// m_axis      out        o_m_axis_tvalid/i_m_axis_tready tdata start, length; tuser flags
// cfg         in         i_cfg_valid/o_cfg_ready         index, 5-bit unit limit
//
// A byte that breaks a pending sequence makes the front decoder first flush each pending
// byte (up to three) as a one-byte point. At end of text the pending bytes are flushed,
// then the marker is sent, and the back walks the ring one entry a cycle, up to
// RING_DEPTH entries, before the result shows.
// Reset is synchronous; the ring needs no clearing pass.
// A four-record queue parts decoder and ring, so either side can stall on its own.

module utf8_context_tail_trimmer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [7:0]                          i_s_axis_tdata,  // text_byte
    input  wire logic                                i_s_axis_tuser,  // byte_present
    input  wire logic                                i_s_axis_tlast,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    output logic [23:0]                              o_m_axis_tdata,  // keep_start, keep_length
    output logic [1:0]                               o_m_axis_tuser,  // ends_latin, offset_overflow
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [u8tt_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [u8tt_pkg::LIMIT_BITS-1:0]     i_cfg_data
);

    u8tt_pkg::t_rec                         f_rec, q_rec;
    logic                                   f_valid, f_ready;
    logic                                   q_valid, q_ready;
    logic [u8tt_pkg::START_BITS-1:0]        res_start;
    logic [u8tt_pkg::KEEP_BITS-1:0]         res_len;
    logic                                   res_latin, res_ovf;

    // decoder
    u8tt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_present   (i_s_axis_tuser),
        .i_eot       (i_s_axis_tlast),
        .o_rec_valid (f_valid),
        .o_rec       (f_rec),
        .i_rec_ready (f_ready)
    );

    // record queue
    u8tt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_rec   (f_rec),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_rec   (q_rec)
    );

    // run ring and tail walk
    u8tt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rec_valid (q_valid),
        .o_rec_ready (q_ready),
        .i_rec       (q_rec),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_start     (res_start),
        .o_len       (res_len),
        .o_latin     (res_latin),
        .o_ovf       (res_ovf)
    );

    // result packing
    assign o_m_axis_tdata = {res_len, res_start};
    assign o_m_axis_tuser = {res_ovf, res_latin};

endmodule

`default_nettype wire

@@ tb/utf8_context_tail_trimmer_tb.sv @@
`default_nettype none

module utf8_context_tail_trimmer_tb;

    localparam int unsigned      STALL_LIMIT   = 4000;
    localparam int unsigned      SETTLE_CYCLES = u8tt_pkg::RING_DEPTH + 20;
    localparam int unsigned      HOLD_CYCLES   = 300;
    localparam int unsigned      PHASE_ITEMS   = 300;
    localparam longint unsigned  POS_LIMIT     = (64'd1 << u8tt_pkg::OFFSET_BITS) - 64'd1;

    typedef logic [7:0] t_text [$];

    // one end-of-text report as it leaves the block
    typedef struct packed {
        logic [15:0] start;
        logic [7:0]  len;
        logic        latin;
        logic        ovf;
    } t_tail;

    // works out the kept suffix of each text and holds the reports still to come
    class t_tail_predictor;
        logic [u8tt_pkg::LIMIT_BITS-1:0] cjk_limit;
        logic [u8tt_pkg::LIMIT_BITS-1:0] latin_limit;
        logic [7:0]            held [3];
        int unsigned           held_n;
        longint unsigned       pos;
        logic [16:0]           ring [u8tt_pkg::RING_DEPTH];
        int unsigned           ring_n;
        int unsigned           head;
        u8tt_pkg::t_lang       run_lang;
        logic                  ovf;
        t_tail                 expected_tails [$];
        int unsigned           errors;

        function new();
            cjk_limit   = u8tt_pkg::CJK_LIMIT_RST;
            latin_limit = u8tt_pkg::LATIN_LIMIT_RST;
            errors      = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (held[k]) held[k] = 8'h00;
            foreach (ring[k]) ring[k] = '0;
            held_n   = 0;
            pos      = 0;
            ring_n   = 0;
            head     = 0;
            run_lang = u8tt_pkg::LANG_OTHER;
            ovf      = 1'b0;
        endfunction

        function int unsigned lead_len(input logic [7:0] b);
            if (b[7:5] == 3'b110) return 2;
            if (b[7:4] == 4'b1110) return 3;
            if (b[7:3] == 5'b11110) return 4;
            return 1;
        endfunction

        function u8tt_pkg::t_lang lang_of(input int unsigned cp);
            if ((cp >= 32'h3400 && cp <= 32'h4dbf) || (cp >= 32'h4e00 && cp <= 32'h9fff) ||
                (cp >= 32'h20000 && cp <= 32'h2a6df))
                return u8tt_pkg::LANG_CJK;
            // folding bit 5 maps upper case onto lower case
            if ((cp | 32'h20) >= 32'h61 && (cp | 32'h20) <= 32'h7a) return u8tt_pkg::LANG_LATIN;
            return u8tt_pkg::LANG_OTHER;
        endfunction

        // append a point to the trailing run, restarting it on a class change
        function void push_point(input longint unsigned start, input int unsigned cp);
            u8tt_pkg::t_lang l;
            logic [16:0]     e;
            l       = lang_of(cp);
            e[15:0] = (start > 64'hffff) ? 16'hffff : start[15:0];
            e[16]   = (cp > 32'hffff);
            if (l != run_lang) begin
                ring_n   = 0;
                run_lang = l;
            end
            ring[head] = e;
            head = (head + 1) % u8tt_pkg::RING_DEPTH;
            if (ring_n < u8tt_pkg::RING_DEPTH) ring_n++;
        endfunction

        function longint unsigned held_start(input int unsigned k);
            longint unsigned base;
            base = (pos >= held_n) ? pos - held_n : 0;
            return base + k;
        endfunction

        function void flush_held();
            for (int unsigned k = 0; k < held_n && k < 3; k++)
                push_point(held_start(k), held[k]);
            held_n = 0;
        endfunction

        function void feed(input logic [7:0] b);
            longint unsigned here;
            longint unsigned st;
            int unsigned     need;
            int unsigned     cp;
            bit              taken;
            here  = pos;
            taken = 1'b0;
            if (held_n > 0) begin
                if (b[7:6] == 2'b10) begin
                    need = lead_len(held[0]);
                    if (held_n + 1 >= need) begin
                        if (need == 2) cp = {held[0][4:0], b[5:0]};
                        else if (need == 3) cp = {held[0][3:0], held[1][5:0], b[5:0]};
                        else cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
                        st     = held_start(0);
                        held_n = 0;
                        push_point(st, cp);
                    end else if (held_n < 3) begin
                        held[held_n] = b;
                        held_n++;
                    end
                    taken = 1'b1;
                end else begin
                    flush_held();
                end
            end
            if (!taken) begin
                if (lead_len(b) == 1) begin
                    push_point(here, b);
                end else begin
                    held[0] = b;
                    held_n  = 1;
                end
            end
            // byte offset saturates and flags the overflow
            if (pos >= POS_LIMIT) begin
                pos = POS_LIMIT;
                ovf = 1'b1;
            end else begin
                pos++;
            end
        endfunction

        // note an accepted input transaction
        function void note_item(input logic [7:0] b, input logic present, input logic eot);
            longint unsigned start;
            longint unsigned kept;
            int unsigned     limit;
            int unsigned     units;
            logic [16:0]     e;
            t_tail           t;
            if (present) feed(b);
            if (!eot) return;
            flush_held();
            start   = pos;
            t.latin = 1'b0;
            // walk back over the trailing run until the unit budget is used
            if (ring_n > 0 && run_lang != u8tt_pkg::LANG_OTHER) begin
                limit   = (run_lang == u8tt_pkg::LANG_CJK) ? cjk_limit : latin_limit;
                units   = 0;
                t.latin = (run_lang == u8tt_pkg::LANG_LATIN);
                for (int unsigned i = 0; i < ring_n; i++) begin
                    e = ring[(head + u8tt_pkg::RING_DEPTH - 1 - i) % u8tt_pkg::RING_DEPTH];
                    if (units >= limit) break;
                    start = e[15:0];
                    units += e[16] ? 2 : 1;
                end
            end
            kept = (pos >= start) ? pos - start : 0;
            if (kept >= u8tt_pkg::KEEP_BUF_BYTES) kept = u8tt_pkg::KEEP_BUF_BYTES - 1;
            t.start = start[15:0];
            t.len   = kept[7:0];
            t.ovf   = ovf;
            expected_tails.push_back(t);
            clear_text();
        endfunction

        function void compare(input string field, input logic [15:0] want,
                              input logic [15:0] got);
            if (got !== want) begin
                $display("%0t  %s mismatch: expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        // check an accepted output transaction against the oldest report
        function void check_tail(input logic [23:0] data, input logic [1:0] user);
            t_tail t;
            if (expected_tails.size() == 0) begin
                $display("%0t  report with none expected: expected nothing, actual start %0d len %0d",
                         $time, data[15:0], data[23:16]);
                errors++;
                return;
            end
            t = expected_tails.pop_front();
            compare("keep_start", t.start, data[15:0]);
            compare("keep_length", 16'(t.len), 16'(data[23:16]));
            compare("ends_latin", 16'(t.latin), 16'(user[0]));
            compare("offset_overflow", 16'(t.ovf), 16'(user[1]));
        endfunction
    endclass

    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [7:0]                        i_s_axis_tdata  = 8'h00;
    logic                              i_s_axis_tuser  = 1'b0;
    logic                              i_s_axis_tlast  = 1'b0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    logic [23:0]                       o_m_axis_tdata;
    logic [1:0]                        o_m_axis_tuser;
    logic                              i_cfg_valid     = 1'b0;
    logic                              o_cfg_ready;
    logic [u8tt_pkg::CFG_IDX_BITS-1:0] i_cfg_index     = u8tt_pkg::CFG_CJK_LIMIT;
    logic [u8tt_pkg::LIMIT_BITS-1:0]   i_cfg_data      = '0;

    t_tail_predictor tails;
    t_text         text_buf;
    int unsigned   send_idle    = 0;
    int unsigned   recv_idle    = 0;
    int unsigned   hold_request = 0;
    int unsigned   items_sent   = 0;
    int unsigned   cjk_edges [12] = '{32'h33ff, 32'h3400, 32'h4dbf, 32'h4dc0, 32'h4dff,
                                      32'h4e00, 32'h9fff, 32'ha000, 32'h1ffff, 32'h20000,
                                      32'h2a6df, 32'h2a6e0};

    utf8_context_tail_trimmer uut (.*);

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // utf-8 encoding of one code point
    function automatic void add_point(input int unsigned cp);
        if (cp < 32'h80) begin
            text_buf.push_back(cp[7:0]);
        end else if (cp < 32'h800) begin
            text_buf.push_back({3'b110, cp[10:6]});
            text_buf.push_back({2'b10, cp[5:0]});
        end else if (cp < 32'h10000) begin
            text_buf.push_back({4'b1110, cp[15:12]});
            text_buf.push_back({2'b10, cp[11:6]});
            text_buf.push_back({2'b10, cp[5:0]});
        end else begin
            text_buf.push_back({5'b11110, cp[20:18]});
            text_buf.push_back({2'b10, cp[17:12]});
            text_buf.push_back({2'b10, cp[11:6]});
            text_buf.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // one random point, weighted by the flavour of the text
    function automatic void add_random_point(input int unsigned theme);
        int unsigned r;
        int unsigned lat;
        int unsigned cjk;
        int unsigned bad;
        int unsigned len;
        case (theme)
            0: begin lat = 85; cjk = 5;  bad = 3;  end
            1: begin lat = 5;  cjk = 80; bad = 5;  end
            2: begin lat = 35; cjk = 35; bad = 10; end
            default: begin lat = 10; cjk = 10; bad = 50; end
        endcase
        r = $urandom_range(99);
        if (r < lat) begin
            add_point($urandom_range(1) ? $urandom_range(32'h41, 32'h5a)
                                        : $urandom_range(32'h61, 32'h7a));
        end else if (r < lat + cjk) begin
            case ($urandom_range(9))
                0: add_point(cjk_edges[$urandom_range(11)]);
                1, 2: add_point($urandom_range(32'h3400, 32'h4dbf));
                3, 4, 5, 6: add_point($urandom_range(32'h4e00, 32'h9fff));
                default: add_point($urandom_range(32'h20000, 32'h2a6df));
            endcase
        end else if (r < lat + cjk + bad) begin
            case ($urandom_range(5))
                0: text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
                1: text_buf.push_back(8'($urandom_range(255)));
                2: text_buf.push_back(8'($urandom_range(8'hf8, 8'hff)));
                3: begin
                    // overlong two-byte form
                    text_buf.push_back(8'hc1);
                    text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end
                4: begin
                    // overlong three-byte form
                    text_buf.push_back(8'he0);
                    text_buf.push_back(8'h81);
                    text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end
                default: begin
                    // sequence cut short
                    len = text_buf.size();
                    add_point($urandom_range(32'h80, 32'h10ffff));
                    repeat ($urandom_range(1, text_buf.size() - len - 1)) void'(text_buf.pop_back());
                end
            endcase
        end else begin
            case ($urandom_range(3))
                0: add_point($urandom_range(32'h7f));
                1: add_point($urandom_range(32'h80, 32'h7ff));
                2: add_point($urandom_range(32'h800, 32'hffff));
                default: add_point($urandom_range(32'h10000, 32'h10ffff));
            endcase
        end
    endfunction

    // offer one input transaction, idling first at random
    task automatic send_item(input logic [7:0] b, input logic present, input logic eot);
        while ($urandom_range(99) < send_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= present;
        i_s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tails.note_item(b, present, eot);
        if (present || eot) items_sent++;
    endtask

    // send the buffered text, ending on its last byte or on a bare marker
    task automatic send_text(input bit on_byte);
        bit last_on_byte;
        last_on_byte = on_byte && (text_buf.size() != 0);
        foreach (text_buf[i]) begin
            if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(text_buf[i], 1'b1, last_on_byte && (i == text_buf.size() - 1));
        end
        if (!last_on_byte) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // stop sending and wait for every report, optionally letting the block settle
    task automatic drain_block(input bit settle);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tails.expected_tails.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both unit limits, one transaction each
    task automatic set_limits(input logic [u8tt_pkg::LIMIT_BITS-1:0] cjk,
                              input logic [u8tt_pkg::LIMIT_BITS-1:0] lat);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= u8tt_pkg::CFG_CJK_LIMIT;
        i_cfg_data  <= cjk;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= u8tt_pkg::CFG_LATIN_LIMIT;
        i_cfg_data  <= lat;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid       <= 1'b0;
        tails.cjk_limit   = cjk;
        tails.latin_limit = lat;
    endtask

    // result side: check, then pick the ready level for the next cycle
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                tails.check_tail(o_m_axis_tdata, o_m_axis_tuser);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [u8tt_pkg::LIMIT_BITS-1:0] cjk_sel;
        logic [u8tt_pkg::LIMIT_BITS-1:0] latin_sel;
        int unsigned           base;
        int unsigned           points;
        int unsigned           theme;
        bit                    paused;
        tails = new();
        repeat (8) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        send_idle = 19;
        recv_idle = 78;

        // empty text, then a transaction with neither byte nor end
        text_buf.delete();
        send_text(1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        // zero byte and the letter boundaries, ending on a latin run
        text_buf.delete();
        add_point(32'h00);
        add_point(32'h5b);
        add_point(32'h40);
        add_point(32'h7b);
        add_point(32'h60);
        add_point(32'h61);
        add_point(32'h7a);
        add_point(32'h41);
        add_point(32'h5a);
        send_text(1'b1);
        // overlong letter
        text_buf.delete();
        text_buf.push_back(8'hc1);
        text_buf.push_back(8'h81);
        send_text(1'b0);
        // cjk range edges, one of them outside the basic plane
        text_buf.delete();
        add_point(32'h3400);
        add_point(32'h2a6df);
        send_text(1'b1);
        // sequence left short at the end
        text_buf.delete();
        text_buf.push_back(8'he4);
        text_buf.push_back(8'hb8);
        send_text(1'b0);
        // bad lead bytes before a letter
        text_buf.delete();
        text_buf.push_back(8'hff);
        text_buf.push_back(8'hc3);
        add_point(32'h41);
        send_text(1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    cjk_sel = 5'd20; latin_sel = 5'd1; send_idle = 19; recv_idle = 78;
                end
                1: begin
                    cjk_sel = 5'd1; latin_sel = 5'd20; send_idle = 78; recv_idle = 19;
                end
                default: begin
                    cjk_sel   = 5'($urandom_range(1, 20));
                    latin_sel = 5'($urandom_range(1, 20));
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            drain_block(1'b1);
            set_limits(cjk_sel, latin_sel);
            // long receiver hold while texts keep coming
            if (ph == 1) hold_request = HOLD_CYCLES;
            base   = items_sent;
            paused = 1'b0;
            while (items_sent - base < PHASE_ITEMS) begin
                if (ph == 2 && !paused && items_sent - base >= PHASE_ITEMS / 2) begin
                    drain_block(1'b0);
                    paused = 1'b1;
                end
                text_buf.delete();
                theme  = $urandom_range(3);
                points = ($urandom_range(9) == 0) ? $urandom_range(15, 32) : $urandom_range(1, 8);
                if ($urandom_range(29) == 0) points = 0;
                repeat (points) add_random_point(theme);
                send_text($urandom_range(1));
            end
        end

        drain_block(1'b1);
        if (tails.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
